### src/tli_pkg.sv
// tli_pkg: shared constants, codes and types of the table linear interpolator
// no dependencies
`timescale 1ns / 1ps
package tli_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int VAL_W       = 32;
    localparam int MAG_W       = VAL_W + 1;
    localparam int PROD_W      = 2 * MAG_W;
    localparam int Q_W         = 41;
    localparam int SUM_W       = Q_W + 1;
    localparam int MD_CNT_W    = $clog2(PROD_W);
    localparam int MODE_W      = 2;
    localparam int OP_W        = 2;
    localparam int ST_W        = 3;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [MODE_W-1:0] MODE_ZERO_EXT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ZERO     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLAMP    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE    = 2'd3;

    localparam logic [ST_W-1:0] ST_OK     = 3'd0;
    localparam logic [ST_W-1:0] ST_BELOW  = 3'd1;
    localparam logic [ST_W-1:0] ST_ABOVE  = 3'd2;
    localparam logic [ST_W-1:0] ST_FEW    = 3'd3;
    localparam logic [ST_W-1:0] ST_ZERO_W = 3'd4;
    localparam logic [ST_W-1:0] ST_FULL   = 3'd5;
    localparam logic [ST_W-1:0] ST_ORDER  = 3'd6;

    typedef struct packed {
        logic [VAL_W-1:0] x;
        logic [VAL_W-1:0] y;
    } t_point;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] mag_a;
        logic [MAG_W-1:0] mag_b;
        logic [MAG_W-1:0] divisor;
    } t_md_req;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quot;
    } t_md_rsp;

endpackage

### src/tli_ifs.sv
// tli_in_if, tli_out_if: valid/ready channels for input and result words
// depends on tli_pkg
`timescale 1ns / 1ps
interface tli_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [tli_pkg::OP_W-1:0]             opcode;
    logic signed [tli_pkg::VAL_W-1:0]     point_x;
    logic signed [tli_pkg::VAL_W-1:0]     point_y;

    modport source (output valid, output opcode, output point_x, output point_y, input ready);
    modport sink (input valid, input opcode, input point_x, input point_y, output ready);
endinterface

interface tli_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tli_pkg::VAL_W-1:0]     result_value;
    logic [tli_pkg::ST_W-1:0]             status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink (input valid, input result_value, input status, output ready);
endinterface

### src/tli_table.sv
// tli_table: point memory, one write port and one registered read port
// depends on tli_pkg
`timescale 1ns / 1ps
module tli_table (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [tli_pkg::ADDR_W-1:0] i_wr_addr,
    input  tli_pkg::t_point            i_wr_data,
    input  logic [tli_pkg::ADDR_W-1:0] i_rd_addr,
    output tli_pkg::t_point            o_rd_data
);
    import tli_pkg::*;

    t_point r_mem [TABLE_DEPTH];
    t_point r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/tli_muldiv.sv
// tli_muldiv: shift-add multiplier followed by restoring divider, one bit a cycle
// quotient clamped to 2^40; depends on tli_pkg
`timescale 1ns / 1ps
module tli_muldiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tli_pkg::t_md_req i_req,
    output tli_pkg::t_md_rsp o_rsp
);
    import tli_pkg::*;

    typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} t_md_state;

    t_md_state             r_state;
    logic [PROD_W-1:0]     r_acc;
    logic [PROD_W-1:0]     r_mcand;
    logic [MAG_W-1:0]      r_mplier;
    logic [MAG_W-1:0]      r_rem;
    logic [MAG_W-1:0]      r_div;
    logic [MD_CNT_W-1:0]   r_cnt;
    logic                  r_done;

    logic [MAG_W:0]        n_trial;
    logic                  n_fits;

    assign n_trial = {r_rem, r_acc[PROD_W-1]};
    assign n_fits  = n_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                MD_IDLE: begin
                    if (i_req.start) begin
                        r_acc    <= '0;
                        r_mcand  <= PROD_W'(i_req.mag_a);
                        r_mplier <= i_req.mag_b;
                        r_div    <= i_req.divisor;
                        r_rem    <= '0;
                        r_cnt    <= MD_CNT_W'(MAG_W - 1);
                        r_state  <= MD_MUL;
                    end
                end
                MD_MUL: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[MAG_W-1:1]};
                    if (r_cnt == '0) begin
                        r_cnt   <= MD_CNT_W'(PROD_W - 1);
                        r_state <= MD_DIV;
                    end else begin
                        r_cnt <= r_cnt - MD_CNT_W'(1);
                    end
                end
                MD_DIV: begin
                    r_rem <= n_fits ? MAG_W'(n_trial - {1'b0, r_div}) : n_trial[MAG_W-1:0];
                    r_acc <= {r_acc[PROD_W-2:0], n_fits};
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= MD_IDLE;
                    end else begin
                        r_cnt <= r_cnt - MD_CNT_W'(1);
                    end
                end
                default: r_state <= MD_IDLE;
            endcase
        end
    end

    // clamp to 2^40
    logic n_big;
    assign n_big = (|r_acc[PROD_W-1:Q_W]) || (r_acc[Q_W-1] && (|r_acc[Q_W-2:0]));

    assign o_rsp.done = r_done;
    assign o_rsp.quot = n_big ? (Q_W'(1) << (Q_W - 1)) : r_acc[Q_W-1:0];

endmodule

### src/table_linear_interpolator.sv
// table_linear_interpolator: point table with binary search and Q16.16 interpolation
// depends on tli_pkg, tli_ifs (tli_in_if, tli_out_if), tli_table, tli_muldiv
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    opcode, point_x, point_y
//  o_out     out  valid/ready    result_value, status
//  i_cfg_*   in   write enable   range_mode
//
// clear, load and unused opcodes go from acceptance through S_FINISH to the output register
// an interpolated query makes two end-point reads, up to eight search reads,
// two segment reads, then 33 multiply and 66 divide steps in the shared
// bit-serial unit
// i_in.ready is high only when the sequencer is idle; a result waits in the
// output register while the next word is accepted
// reset is synchronous: empty table, range_mode 0, no pending result
`timescale 1ns / 1ps
module table_linear_interpolator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tli_pkg::MODE_W-1:0] i_cfg_data,
    tli_in_if.sink                     i_in,
    tli_out_if.source                  o_out
);
    import tli_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK_LO, S_CHK_HI, S_SEARCH, S_CMP, S_SEG_A, S_SEG_B, S_WAIT, S_FINISH
    } t_state;

    t_state                   r_state;
    logic [MODE_W-1:0]        r_range_mode;
    logic [CNT_W-1:0]         r_count;
    logic signed [VAL_W-1:0]  r_last;
    logic signed [VAL_W-1:0]  r_qx;
    logic signed [VAL_W-1:0]  r_x0;
    logic signed [VAL_W-1:0]  r_y0;
    logic [ADDR_W-1:0]        r_lo;
    logic [ADDR_W-1:0]        r_hi;
    logic [ADDR_W-1:0]        r_mid;
    logic [ADDR_W-1:0]        r_seg;
    logic signed [VAL_W-1:0]  r_value;
    logic [ST_W-1:0]          r_status;
    logic                     r_neg;
    logic                     r_md_start;
    logic [MAG_W-1:0]         r_mag_a;
    logic [MAG_W-1:0]         r_mag_b;
    logic [MAG_W-1:0]         r_div;
    logic                     r_out_valid;
    logic signed [VAL_W-1:0]  r_out_value;
    logic [ST_W-1:0]          r_out_status;

    logic [MODE_W-1:0]        mode;
    logic [CNT_W-1:0]         last_full;
    logic [ADDR_W-1:0]        last_idx;
    logic [ADDR_W-1:0]        n_mid;
    logic                     span_open;
    logic [ADDR_W-1:0]        rd_addr;
    t_point                   rd_data;
    logic signed [VAL_W-1:0]  rd_x;
    logic signed [VAL_W-1:0]  rd_y;
    logic                     wr_en;
    t_point                   wr_data;
    logic                     in_acc;
    logic signed [MAG_W-1:0]  n_width;
    logic signed [MAG_W-1:0]  n_dy;
    logic signed [MAG_W-1:0]  n_dx;
    logic signed [SUM_W-1:0]  n_sum;
    logic                     ovf_hi;
    logic                     ovf_lo;
    t_md_req                  md_req;
    t_md_rsp                  md_rsp;

    assign mode      = (r_range_mode == MODE_SPARE) ? MODE_ZERO : r_range_mode;
    assign last_full = r_count - CNT_W'(1);
    assign last_idx  = last_full[ADDR_W-1:0];
    assign span_open = (r_hi - r_lo) > ADDR_W'(1);
    assign n_mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign rd_x      = $signed(rd_data.x);
    assign rd_y      = $signed(rd_data.y);
    assign in_acc    = i_in.valid && i_in.ready;

    assign i_in.ready = (r_state == S_IDLE);

    assign wr_en   = in_acc && (i_in.opcode == OP_LOAD) && !r_count[CNT_W-1]
                     && !((r_count != '0) && (i_in.point_x < r_last));
    assign wr_data = '{x: i_in.point_x, y: i_in.point_y};

    always_comb begin
        unique case (r_state)
            S_CHK_LO: rd_addr = last_idx;
            S_CHK_HI: rd_addr = last_idx - ADDR_W'(1);
            S_SEARCH: rd_addr = span_open ? n_mid : r_lo;
            S_SEG_A:  rd_addr = r_seg + ADDR_W'(1);
            default:  rd_addr = '0;
        endcase
    end

    assign n_width = {rd_x[VAL_W-1], rd_x} - {r_x0[VAL_W-1], r_x0};
    assign n_dy    = {rd_y[VAL_W-1], rd_y} - {r_y0[VAL_W-1], r_y0};
    assign n_dx    = {r_qx[VAL_W-1], r_qx} - {r_x0[VAL_W-1], r_x0};

    assign n_sum  = r_neg ? (SUM_W'(r_y0) - $signed({1'b0, md_rsp.quot}))
                          : (SUM_W'(r_y0) + $signed({1'b0, md_rsp.quot}));
    assign ovf_hi = !n_sum[SUM_W-1] && (|n_sum[SUM_W-2:VAL_W-1]);
    assign ovf_lo = n_sum[SUM_W-1] && !(&n_sum[SUM_W-2:VAL_W-1]);

    assign md_req = '{start: r_md_start, mag_a: r_mag_a, mag_b: r_mag_b, divisor: r_div};

    tli_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tli_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_range_mode <= MODE_ZERO_EXT;
            r_count      <= '0;
            r_last       <= '0;
            r_md_start   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_md_start <= 1'b0;
            if (i_cfg_we) begin
                r_range_mode <= i_cfg_data;
            end
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_qx     <= i_in.point_x;
                        r_value  <= '0;
                        r_status <= ST_OK;
                        r_state  <= S_FINISH;
                        unique case (i_in.opcode)
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_last  <= '0;
                            end
                            OP_LOAD: begin
                                if (r_count[CNT_W-1]) begin
                                    r_status <= ST_FULL;
                                end else if (!wr_en) begin
                                    r_status <= ST_ORDER;
                                end else begin
                                    r_count <= r_count + CNT_W'(1);
                                    r_last  <= i_in.point_x;
                                end
                            end
                            OP_QUERY: begin
                                if (r_count < CNT_W'(2)) begin
                                    r_status <= ST_FEW;
                                end else begin
                                    r_state <= S_CHK_LO;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_CHK_LO: begin
                    if (r_qx < rd_x) begin
                        r_status <= ST_BELOW;
                        r_value  <= (mode == MODE_CLAMP) ? rd_y : '0;
                        r_state  <= S_FINISH;
                    end else begin
                        r_state <= S_CHK_HI;
                    end
                end
                S_CHK_HI: begin
                    if (r_qx >= rd_x) begin
                        r_status <= (r_qx > rd_x) ? ST_ABOVE : ST_OK;
                        if (mode == MODE_CLAMP) begin
                            r_value <= rd_y;
                            r_state <= S_FINISH;
                        end else if ((mode == MODE_ZERO) && (r_qx > rd_x)) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_seg   <= last_idx - ADDR_W'(1);
                            r_state <= S_SEG_A;
                        end
                    end else begin
                        r_lo    <= '0;
                        r_hi    <= last_idx;
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (span_open) begin
                        r_mid   <= n_mid;
                        r_state <= S_CMP;
                    end else begin
                        r_seg   <= r_lo;
                        r_state <= S_SEG_A;
                    end
                end
                S_CMP: begin
                    if (rd_x <= r_qx) begin
                        r_lo <= r_mid;
                    end else begin
                        r_hi <= r_mid;
                    end
                    r_state <= S_SEARCH;
                end
                S_SEG_A: begin
                    r_x0    <= rd_x;
                    r_y0    <= rd_y;
                    r_state <= S_SEG_B;
                end
                S_SEG_B: begin
                    if (n_width[MAG_W-1] || (n_width == '0)) begin
                        r_status <= ST_ZERO_W;
                        r_value  <= r_y0;
                        r_state  <= S_FINISH;
                    end else begin
                        r_mag_a    <= n_dy[MAG_W-1] ? MAG_W'(-n_dy) : MAG_W'(n_dy);
                        r_mag_b    <= n_dx[MAG_W-1] ? MAG_W'(-n_dx) : MAG_W'(n_dx);
                        r_div      <= MAG_W'(n_width);
                        r_neg      <= n_dy[MAG_W-1] ^ n_dx[MAG_W-1];
                        r_md_start <= 1'b1;
                        r_state    <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (md_rsp.done) begin
                        priority if (ovf_hi) begin
                            r_value <= {1'b0, {(VAL_W-1){1'b1}}};
                        end else if (ovf_lo) begin
                            r_value <= {1'b1, {(VAL_W-1){1'b0}}};
                        end else begin
                            r_value <= n_sum[VAL_W-1:0];
                        end
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= r_value;
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_value;
    assign o_out.status       = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count)) || (r_count == '0)
                 || (r_count == $past(r_count) + CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in.ready)
        else $error("ready high straight after an accepted word");

    a_md_start_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_md_start |-> (r_state == S_WAIT))
        else $error("divider started outside the wait state");

    a_md_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_rsp.done |-> (r_state == S_WAIT))
        else $error("divider result with no query waiting");

endmodule

### bench/tb_table_linear_interpolator.sv
// tb_table_linear_interpolator: self-checking bench with a table and interpolation predictor
// randomised load/query words over all range modes, with idle and stall phases on both sides
// depends on tli_pkg, tli_ifs and table_linear_interpolator
`timescale 1ns / 1ps
module tb_table_linear_interpolator;
    import tli_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam longint X_MIN = -64'sd2147483648;
    localparam longint X_MAX = 64'sd2147483647;
    localparam longint unsigned QUOT_CAP = 64'd1 << 40;
    localparam int N_PHASES = 8;
    localparam int DRAIN_CYCLES = 150;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
    } table_op_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [ST_W-1:0]         status;
    } answer_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [MODE_W-1:0] i_cfg_data;

    tli_in_if  in_if ();
    tli_out_if out_if ();

    table_linear_interpolator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    table_op_t pending_words [$];
    answer_t   expected_answers [$];
    longint    planned_x [$];
    int        src_idle_pct;
    int        sink_stall_pct;
    int        mismatches;

    // predictor state
    logic signed [VAL_W-1:0] tab_x [TABLE_DEPTH];
    logic signed [VAL_W-1:0] tab_y [TABLE_DEPTH];
    int unsigned             tab_count;
    logic signed [VAL_W-1:0] tab_last_x;
    logic [MODE_W-1:0]       tab_mode;

    logic [MODE_W-1:0] phase_mode [N_PHASES] = '{MODE_ZERO, MODE_CLAMP, MODE_SPARE,
        MODE_ZERO_EXT, MODE_CLAMP, MODE_ZERO, MODE_ZERO_EXT, MODE_CLAMP};
    int phase_src  [N_PHASES] = '{0, 64, 0, 16, 0, 64, 0, 16};
    int phase_sink [N_PHASES] = '{0, 0, 64, 16, 0, 0, 64, 16};

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb_table_linear_interpolator: errors");
        $finish;
    end

    function automatic answer_t segment_at(int unsigned seg, longint x, logic [ST_W-1:0] st);
        longint x0, x1, y0, y1, dy, dx, s;
        longint unsigned mag_dy, mag_dx, q;
        logic neg;
        answer_t a;
        x0 = tab_x[seg];
        x1 = tab_x[seg + 1];
        y0 = tab_y[seg];
        y1 = tab_y[seg + 1];
        if (x1 <= x0) begin
            a.value = y0[VAL_W-1:0];
            a.status = ST_ZERO_W;
            return a;
        end
        dy = y1 - y0;
        dx = x - x0;
        mag_dy = (dy < 0) ? -dy : dy;
        mag_dx = (dx < 0) ? -dx : dx;
        neg = (dy < 0) != (dx < 0);
        q = (mag_dy * mag_dx) / (x1 - x0);
        if (q > QUOT_CAP)
            q = QUOT_CAP;
        s = neg ? y0 - longint'(q) : y0 + longint'(q);
        if (s > X_MAX)
            s = X_MAX;
        if (s < X_MIN)
            s = X_MIN;
        a.value = s[VAL_W-1:0];
        a.status = st;
        return a;
    endfunction

    function automatic answer_t interpolate_at(longint x);
        logic [MODE_W-1:0] mode;
        int unsigned last, lo, hi, mid;
        logic above;
        answer_t a;
        mode = (tab_mode == MODE_SPARE) ? MODE_ZERO : tab_mode;
        a.value = '0;
        a.status = ST_OK;
        if (tab_count < 2) begin
            a.status = ST_FEW;
            return a;
        end
        last = tab_count - 1;
        if (x < tab_x[0]) begin
            a.status = ST_BELOW;
            if (mode == MODE_CLAMP)
                a.value = tab_y[0];
            return a;
        end
        if (x >= tab_x[last]) begin
            above = x > tab_x[last];
            a.status = above ? ST_ABOVE : ST_OK;
            if (mode == MODE_CLAMP) begin
                a.value = tab_y[last];
                return a;
            end
            if (mode == MODE_ZERO && above)
                return a;
            return segment_at(last - 1, x, a.status);
        end
        lo = 0;
        hi = last;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (tab_x[mid] <= x)
                lo = mid;
            else
                hi = mid;
        end
        return segment_at(lo, x, ST_OK);
    endfunction

    function automatic answer_t apply_word(table_op_t w);
        answer_t a;
        a.value = '0;
        a.status = ST_OK;
        case (w.op)
            OP_CLEAR: begin
                tab_count = 0;
                tab_last_x = '0;
            end
            OP_LOAD: begin
                if (tab_count >= TABLE_DEPTH) begin
                    a.status = ST_FULL;
                end else if (tab_count > 0 && w.x < tab_last_x) begin
                    a.status = ST_ORDER;
                end else begin
                    tab_x[tab_count] = w.x;
                    tab_y[tab_count] = w.y;
                    tab_count++;
                    tab_last_x = w.x;
                end
            end
            OP_QUERY: a = interpolate_at(w.x);
            default: ;
        endcase
        return a;
    endfunction

    // driver
    always @(posedge i_clk) begin : drive
        table_op_t w;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                w = pending_words.pop_front();
                in_if.valid   <= 1'b1;
                in_if.opcode  <= w.op;
                in_if.point_x <= w.x;
                in_if.point_y <= w.y;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_if.ready <= 1'b0;
        else
            out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // monitor and checker
    always @(posedge i_clk) begin : watch
        table_op_t w;
        answer_t want;
        if (!i_rst_n) begin
            tab_count = 0;
            tab_last_x = '0;
            tab_mode = MODE_ZERO_EXT;
        end else begin
            if (i_cfg_we)
                tab_mode = i_cfg_data;
            if (in_if.valid && in_if.ready) begin
                w.op = in_if.opcode;
                w.x = in_if.point_x;
                w.y = in_if.point_y;
                expected_answers.push_back(apply_word(w));
            end
            if (out_if.valid && out_if.ready) begin
                if (expected_answers.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result word, expected none, actual %h/%0d",
                             $time, out_if.result_value, out_if.status);
                end else begin
                    want = expected_answers.pop_front();
                    if (out_if.result_value !== want.value) begin
                        mismatches++;
                        $display("%0t: result_value mismatch, expected %h, actual %h",
                                 $time, want.value, out_if.result_value);
                    end
                    if (out_if.status !== want.status) begin
                        mismatches++;
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, out_if.status);
                    end
                end
            end
        end
    end

    function automatic longint rand_below(longint span);
        longint unsigned r;
        r = {$urandom(), $urandom()};
        return longint'(r % span);
    endfunction

    task automatic push_word(logic [OP_W-1:0] op, longint x, longint y);
        table_op_t w;
        w.op = op;
        w.x = x[VAL_W-1:0];
        w.y = y[VAL_W-1:0];
        pending_words.push_back(w);
    endtask

    task automatic push_clear();
        push_word(OP_CLEAR, $urandom(), $urandom());
        planned_x.delete();
    endtask

    task automatic add_points(int k);
        longint step_max, lo, span, x, y;
        logic fresh;
        case ($urandom_range(3))
            0: step_max = 3;
            1: step_max = 1024;
            2: step_max = 65536;
            default: step_max = (k > 32) ? 65536 : 64'd1 << 26;
        endcase
        fresh = (planned_x.size() == 0);
        lo = fresh ? X_MIN : planned_x[$];
        span = X_MAX - lo - longint'(k) * step_max;
        if (span <= 0) begin
            push_clear();
            fresh = 1'b1;
            lo = X_MIN;
            span = X_MAX - lo - longint'(k) * step_max;
        end
        x = fresh ? lo + rand_below(span + 1) : lo + rand_below(step_max + 1);
        repeat (k) begin
            if ($urandom_range(9) == 0 && planned_x.size() != 0 && planned_x[$] > X_MIN)
                push_word(OP_LOAD, X_MIN + rand_below(planned_x[$] - X_MIN), $urandom());
            else if ($urandom_range(19) == 0)
                push_word(OP_UNUSED, $urandom(), $urandom());
            y = ($urandom_range(3) == 0) ? longint'($urandom_range(2000)) - 1000
                                         : longint'($urandom());
            push_word(OP_LOAD, x, y);
            planned_x.push_back(x);
            x += rand_below(step_max + 1);
        end
    endtask

    task automatic add_queries(int n);
        longint x, a, b;
        int i, kind;
        repeat (n) begin
            kind = $urandom_range(5);
            if (planned_x.size() == 0 && kind < 4)
                kind = 4;
            case (kind)
                0: x = planned_x[$urandom_range(planned_x.size() - 1)];
                1: begin
                    i = $urandom_range(planned_x.size() - 1);
                    a = planned_x[i];
                    b = (i + 1 < planned_x.size()) ? planned_x[i + 1] : a;
                    x = a + rand_below(b - a + 1);
                end
                2: x = (planned_x[0] > X_MIN) ? X_MIN + rand_below(planned_x[0] - X_MIN)
                                              : X_MIN;
                3: x = (planned_x[$] < X_MAX) ? planned_x[$] + 1 + rand_below(X_MAX - planned_x[$])
                                              : X_MAX;
                4: x = longint'($urandom());
                default: x = $urandom_range(1) ? X_MIN : X_MAX;
            endcase
            push_word(OP_QUERY, x, $urandom());
        end
    endtask

    task automatic add_sequence();
        int r, k;
        if ($urandom_range(99) < 80)
            push_clear();
        r = $urandom_range(99);
        k = (r < 15) ? $urandom_range(1) : (r < 80) ? $urandom_range(8, 2) : $urandom_range(20, 9);
        add_points(k);
        add_queries($urandom_range(10, 3));
    endtask

    // fill the table, then overflow it in and out of order
    task automatic add_fill();
        push_clear();
        add_points(TABLE_DEPTH);
        push_word(OP_LOAD, planned_x[$] + 1, $urandom());
        push_word(OP_LOAD, X_MIN, $urandom());
        push_word(OP_LOAD, planned_x[$], $urandom());
        add_queries(12);
    endtask

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pending_words.size() != 0 || in_if.valid || expected_answers.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_mode(logic [MODE_W-1:0] m);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        in_if.valid    = 1'b0;
        in_if.opcode   = OP_CLEAR;
        in_if.point_x  = '0;
        in_if.point_y  = '0;
        out_if.ready   = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = MODE_ZERO_EXT;
        i_rst_n        = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        mismatches     = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_mode(MODE_ZERO_EXT);
        @(negedge i_clk);

        // directed words
        push_word(OP_QUERY, 0, 0);
        push_word(OP_LOAD, 'h10000, X_MAX);
        push_word(OP_QUERY, 'h10000, 0);
        push_word(OP_LOAD, 0, 5);
        push_word(OP_LOAD, 'h10000, X_MIN);
        push_word(OP_QUERY, 'h10000, 0);
        push_word(OP_QUERY, X_MAX, 0);
        push_word(OP_QUERY, 0, 0);
        push_word(OP_UNUSED, X_MIN, X_MAX);
        push_word(OP_CLEAR, X_MAX, X_MIN);
        push_word(OP_LOAD, X_MIN, X_MIN);
        push_word(OP_LOAD, X_MAX, X_MAX);
        push_word(OP_QUERY, X_MIN, 0);
        push_word(OP_QUERY, 0, 0);
        push_word(OP_QUERY, X_MAX, 0);
        push_word(OP_QUERY, -1, -1);
        push_word(OP_CLEAR, 0, 0);
        push_word(OP_LOAD, 0, 0);
        push_word(OP_LOAD, 1, X_MAX);
        push_word(OP_QUERY, X_MAX, 0);
        push_word(OP_LOAD, 2, X_MIN);
        push_word(OP_QUERY, X_MAX, 0);
        push_word(OP_QUERY, 1, 0);
        push_word(OP_CLEAR, 0, 0);

        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            write_mode(phase_mode[p]);
            @(negedge i_clk);
            src_idle_pct   = phase_src[p];
            sink_stall_pct = phase_sink[p];
            repeat (7) add_sequence();
            if (p == 2 || p == 7)
                add_fill();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("tb_table_linear_interpolator: clean");
        else
            $display("tb_table_linear_interpolator: errors");
        $finish;
    end

endmodule
